// ----- rtl/core/encoder_speed_meter_core_defines.svh -----
// assertion macros for the encoder speed meter core
`ifndef ENCODER_SPEED_METER_CORE_DEFINES_SVH
`define ENCODER_SPEED_METER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// property must hold at every edge outside reset
`define ESM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("esm assertion failed");

// condition must never be true outside reset
`define ESM_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("esm forbidden condition seen");

`else

`define ESM_ASSERT(label, clk, rst_n, prop)
`define ESM_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ----- rtl/core/esm_pkg.sv -----
package esm_pkg;

    // default sizes of the count and window counters
    localparam int ESM_COUNT_BITS        = 20;
    localparam int ESM_WINDOW_COUNT_BITS = 16;

    // field widths
    localparam int WIN_LEN_W = 24;
    localparam int EPR_W     = 16;
    localparam int TS_W      = 32;
    localparam int SPEED_W   = 32;
    localparam int TOTAL_W   = 32;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGES_PER_REV = 1'b1;

    localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = 24'd88888;
    localparam logic [EPR_W-1:0]     EPR_RESET     = 16'd540;

    // operation codes
    localparam logic OP_EDGE       = 1'b0;
    localparam logic OP_WINDOW_END = 1'b1;

    // 60e6 us per minute times 16 for four fraction bits
    localparam int                 SCALE_W     = 30;
    localparam logic [SCALE_W-1:0] SPEED_SCALE = 30'd960000000;

    localparam logic [SPEED_W-1:0] SPEED_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [SPEED_W-1:0] SPEED_NEG_MAX = 32'h8000_0000;

    // quotient from the serial divider
    typedef struct packed {
        logic [SPEED_W-1:0] quotient;
        logic               overflow;
    } esm_div_res_t;

endpackage

// ----- rtl/core/esm_if.sv -----
// event request channel
interface esm_in_if
    import esm_pkg::*;
    ();

    logic            valid;
    logic            ready;
    logic            operation;
    logic [TS_W-1:0] timestamp_us;
    logic            direction;

    modport source (
        output valid,
        output operation,
        output timestamp_us,
        output direction,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  timestamp_us,
        input  direction,
        output ready
    );

endinterface

// speed result channel
interface esm_out_if
    import esm_pkg::*;
    ();

    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] speed_rpm_x16;
    logic signed [TOTAL_W-1:0] total_count;
    logic                      interval_error;

    modport source (
        output valid,
        output speed_rpm_x16,
        output total_count,
        output interval_error,
        input  ready
    );

    modport sink (
        input  valid,
        input  speed_rpm_x16,
        input  total_count,
        input  interval_error,
        output ready
    );

endinterface

// ----- rtl/core/esm_serial_mul.sv -----
module esm_serial_mul
    import esm_pkg::*;
#(
    parameter int A_W = 24,
    parameter int B_W = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               busy,
    output logic [A_W+B_W-1:0] product
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]     a_reg;
    logic [A_W+B_W-1:0] acc_reg;
    logic [A_W+B_W-1:0] acc_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic [A_W:0]       sum;

    // one multiplier bit per cycle, lsb first, product shifts right
    always_comb
    begin
        sum      = {1'b0, acc_reg[A_W+B_W-1:B_W]} + (acc_reg[0] ? {1'b0, a_reg} : '0);
        acc_next = {sum, acc_reg[B_W-1:1]};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(B_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            acc_reg <= {{A_W{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign busy    = busy_reg;
    assign product = acc_reg;

endmodule

// ----- rtl/core/esm_serial_div.sv -----
module esm_serial_div
    import esm_pkg::*;
#(
    parameter int NUM_W = 50,
    parameter int DEN_W = 66
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output esm_div_res_t     res
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [SPEED_W-1:0] quo_reg;
    logic               ovf_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic [DEN_W:0]     trial;
    logic [DEN_W+1:0]   diff;
    logic               fits;

    // restoring step: bring in one dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, num_reg[NUM_W-1]};
        diff  = {1'b0, trial} - {2'b00, den_reg};
        fits  = !diff[DEN_W+1];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // datapath, quotient bits past the low word fold into a sticky flag
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[SPEED_W-2:0], fits};
            ovf_reg <= ovf_reg | quo_reg[SPEED_W-1];
        end
    end

    assign busy         = busy_reg;
    assign res.quotient = quo_reg;
    assign res.overflow = ovf_reg;

endmodule

// ----- rtl/core/encoder_speed_meter_core.sv -----
// edge request: taken while idle, no result
// window end without edges: straight to ST_DONE, then into the result register once it is free
// window end with edges: the window and scale multipliers run in ST_MUL, the interval
//   multiplier in ST_DEN and the bit-serial divider in ST_DIV, then ST_DONE
// one request in flight; the result register frees the input side while it waits
// rst_n is asynchronous: counters, totals and tail gap clear, registers take defaults
`include "encoder_speed_meter_core_defines.svh"

module encoder_speed_meter_core
    import esm_pkg::*;
#(
    parameter int COUNT_BITS        = ESM_COUNT_BITS,
    parameter int WINDOW_COUNT_BITS = ESM_WINDOW_COUNT_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    esm_in_if.sink                events,
    esm_out_if.source             results
);

    localparam int WPROD_W = WIN_LEN_W + WINDOW_COUNT_BITS;
    localparam int IVAL_W  = ((WPROD_W > TS_W) ? WPROD_W : TS_W) + 2;
    localparam int IMAG_W  = IVAL_W - 1;
    localparam int DEN_W   = IMAG_W + EPR_W;
    localparam int NUM_W   = COUNT_BITS + SCALE_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DEN  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg;

    logic [WIN_LEN_W-1:0]         window_length_reg;
    logic [EPR_W-1:0]             epr_reg;
    logic [COUNT_BITS-1:0]        edge_count_reg;
    logic [TS_W-1:0]              last_edge_reg;
    logic [WINDOW_COUNT_BITS-1:0] windows_reg;
    logic [TS_W-1:0]              prev_gap_reg;
    logic [TOTAL_W-1:0]           total_reg;
    logic signed [TS_W:0]         diff_reg;
    logic                         neg_reg;
    logic [SPEED_W-1:0]           speed_reg;
    logic                         err_reg;
    logic                         out_valid_reg;
    logic [SPEED_W-1:0]           out_speed_reg;
    logic [TOTAL_W-1:0]           out_total_reg;
    logic                         out_err_reg;

    logic                         ev_accept;
    logic                         win_end;
    logic                         has_edges;
    logic [TS_W-1:0]              tail;
    logic [COUNT_BITS-1:0]        mag;
    logic [WINDOW_COUNT_BITS-1:0] windows_inc;
    logic                         mul_start;
    logic                         den_start;
    logic                         div_start;
    logic                         win_busy;
    logic                         num_busy;
    logic                         den_busy;
    logic                         div_busy;
    logic [WPROD_W-1:0]           win_prod;
    logic [NUM_W-1:0]             num_prod;
    logic [DEN_W-1:0]             den_prod;
    logic signed [IVAL_W-1:0]     ival;
    logic                         ival_pos;
    logic [EPR_W-1:0]             epr_eff;
    esm_div_res_t                 div_res;
    logic [SPEED_W-1:0]           speed_sat;
    logic                         out_free;

    // request decode
    always_comb
    begin
        ev_accept   = events.valid && events.ready;
        win_end     = events.operation == OP_WINDOW_END;
        has_edges   = edge_count_reg != '0;
        tail        = events.timestamp_us - last_edge_reg;
        mag         = edge_count_reg[COUNT_BITS-1] ? (~edge_count_reg + 1'b1) : edge_count_reg;
        windows_inc = windows_reg + 1'b1;
        mul_start   = ev_accept && win_end && has_edges;
        epr_eff     = (epr_reg == '0) ? EPR_W'(1) : epr_reg;
        out_free    = !out_valid_reg || results.ready;
    end

    // interval = window length * windows + previous tail gap - tail gap
    always_comb
    begin
        ival      = $signed(IVAL_W'(win_prod)) + IVAL_W'(diff_reg);
        ival_pos  = !ival[IVAL_W-1] && (ival != '0);
        den_start = (state_reg == ST_MUL) && !win_busy && !num_busy && ival_pos;
        div_start = (state_reg == ST_DEN) && !den_busy;
    end

    // saturate the quotient and apply the sign
    always_comb
    begin
        if (!neg_reg)
        begin
            speed_sat = (div_res.overflow || div_res.quotient[SPEED_W-1]) ?
                        SPEED_POS_MAX : div_res.quotient;
        end
        else if (div_res.overflow ||
                 (div_res.quotient[SPEED_W-1] && (div_res.quotient[SPEED_W-2:0] != '0)))
        begin
            speed_sat = SPEED_NEG_MAX;
        end
        else
        begin
            speed_sat = ~div_res.quotient + 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WIN_LEN_RESET;
            epr_reg           <= EPR_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_WINDOW_LENGTH: window_length_reg <= cfg_wr_data[WIN_LEN_W-1:0];
                CFG_EDGES_PER_REV: epr_reg           <= cfg_wr_data[EPR_W-1:0];
                default: ;
            endcase
        end
    end

    // measurement state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_count_reg <= '0;
            last_edge_reg  <= '0;
            windows_reg    <= '0;
            prev_gap_reg   <= '0;
            total_reg      <= '0;
        end
        else if (ev_accept)
        begin
            if (!win_end)
            begin
                last_edge_reg  <= events.timestamp_us;
                edge_count_reg <= events.direction ? edge_count_reg + 1'b1
                                                   : edge_count_reg - 1'b1;
            end
            else
            begin
                total_reg <= total_reg + TOTAL_W'($signed(edge_count_reg));
                if (has_edges)
                begin
                    edge_count_reg <= '0;
                    windows_reg    <= '0;
                    prev_gap_reg   <= tail;
                end
                else
                begin
                    windows_reg <= windows_inc;
                end
            end
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (ev_accept && win_end)
                    begin
                        state_reg <= has_edges ? ST_MUL : ST_DONE;
                    end
                end
                ST_MUL:
                begin
                    if (!win_busy && !num_busy)
                    begin
                        state_reg <= ival_pos ? ST_DEN : ST_DONE;
                    end
                end
                ST_DEN:
                begin
                    if (!den_busy)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // working values of one window computation
    always_ff @(posedge clk)
    begin
        if (ev_accept && win_end)
        begin
            diff_reg  <= $signed({1'b0, prev_gap_reg}) - $signed({1'b0, tail});
            neg_reg   <= edge_count_reg[COUNT_BITS-1];
            speed_reg <= '0;
            err_reg   <= 1'b0;
        end
        else if ((state_reg == ST_MUL) && !win_busy && !num_busy && !ival_pos)
        begin
            err_reg <= 1'b1;
        end
        else if ((state_reg == ST_DIV) && !div_busy)
        begin
            speed_reg <= speed_sat;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_DONE) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_speed_reg <= speed_reg;
            out_total_reg <= total_reg;
            out_err_reg   <= err_reg;
        end
    end

    // window length times windows since the last update
    esm_serial_mul #(
        .A_W (WIN_LEN_W),
        .B_W (WINDOW_COUNT_BITS)
    ) u_win_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (window_length_reg),
        .b       (windows_inc),
        .busy    (win_busy),
        .product (win_prod)
    );

    // edge count magnitude times the rpm scale
    esm_serial_mul #(
        .A_W (SCALE_W),
        .B_W (COUNT_BITS)
    ) u_num_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (SPEED_SCALE),
        .b       (mag),
        .busy    (num_busy),
        .product (num_prod)
    );

    // interval times edges per revolution
    esm_serial_mul #(
        .A_W (IMAG_W),
        .B_W (EPR_W)
    ) u_den_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (den_start),
        .a       (ival[IMAG_W-1:0]),
        .b       (epr_eff),
        .busy    (den_busy),
        .product (den_prod)
    );

    esm_serial_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_prod),
        .den   (den_prod),
        .busy  (div_busy),
        .res   (div_res)
    );

    // channel outputs
    assign events.ready           = state_reg == ST_IDLE;
    assign results.valid          = out_valid_reg;
    assign results.speed_rpm_x16  = $signed(out_speed_reg);
    assign results.total_count    = $signed(out_total_reg);
    assign results.interval_error = out_err_reg;

    // checks
    `ESM_ASSERT(a_count_cleared, clk, rst_n, (mul_start) |=> (edge_count_reg == '0 && windows_reg == '0))
    `ESM_ASSERT(a_total_hold, clk, rst_n, (state_reg != ST_IDLE) |=> $stable(total_reg))
    `ESM_ASSERT(a_div_follows, clk, rst_n, (state_reg == ST_DEN && !den_busy) |=> div_busy)
    `ESM_NEVER(a_ready_while_busy, clk, rst_n, events.ready && (win_busy || num_busy || den_busy || div_busy))

endmodule
